// ===== sv/wss_pkg.sv =====
package wss_pkg;

  localparam int CHAR_W          = 32;
  localparam int FUNC_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int MAX_PATTERN_DEF = 16;

  localparam logic [FUNC_W-1:0] FUNC_START    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PAT_CHAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TXT_CHAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TXT_END  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_MATCH    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMATCH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CHAR_W-1:0] TERMINATOR = '0;

  typedef struct packed {
    logic              clear;
    logic              shift;
    logic [CHAR_W-1:0] ch;
  } cell_ctrl_t;

endpackage

// ===== sv/wide_substring_search.sv =====
// Streaming search for the first occurrence of a wide-character pattern. Send a start
// request, then pattern characters (up to MAX_PATTERN), then text characters and an
// optional text end. Each cell of the chain holds one pattern character and a flag that
// says whether the text just seen ends with the pattern prefix up to that cell; every
// text character is broadcast to all cells and the flags step one cell along, so one
// request is taken per cycle. A result (match with start position, no match, or pattern
// overflow) is held in an output register; a new request is taken while that register
// is empty or being drained. At most one result per search.
module wide_substring_search #(
  parameter int MAX_PATTERN = wss_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wss_pkg::FUNC_W-1:0]     in_func,
  input  logic [wss_pkg::CHAR_W-1:0]     in_char_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wss_pkg::STATUS_W-1:0]   out_status,
  output logic [wss_pkg::CHAR_W-1:0]     out_position
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]             plen_r, plen_nxt;
  logic [wss_pkg::CHAR_W-1:0]   count_r, count_nxt;
  logic                         reported_r, reported_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [wss_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [wss_pkg::CHAR_W-1:0]   out_position_r, out_position_nxt;

  wss_pkg::cell_ctrl_t    ctrl;
  logic                   load_any;
  logic [MAX_PATTERN-1:0] cell_load;
  logic [MAX_PATTERN-1:0] flag_r;
  logic [MAX_PATTERN-1:0] flag_nxt;
  logic [MAX_PATTERN-1:0] hit;
  logic                   in_fire;
  logic                   drained;
  logic                   emit;
  logic                   ch_zero;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign drained  = out_valid_r && !out_stall;
  assign ch_zero  = (in_char_value == wss_pkg::TERMINATOR);

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    assign cell_load[k] = load_any && (plen_r == LEN_W'(k));
    assign hit[k]       = flag_nxt[k] && (plen_r == LEN_W'(k + 1));

    wss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .load      (cell_load[k]),
      .prev_flag ((k == 0) ? 1'b1 : flag_r[(k == 0) ? 0 : k - 1]),
      .flag_r    (flag_r[k]),
      .flag_nxt  (flag_nxt[k])
    );
  end

  always_comb begin
    ctrl.clear       = 1'b0;
    ctrl.shift       = 1'b0;
    ctrl.ch          = in_char_value;
    load_any         = 1'b0;
    plen_nxt         = plen_r;
    count_nxt        = count_r;
    reported_nxt     = reported_r;
    emit             = 1'b0;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;

    if (in_fire) begin
      unique case (in_func)
        wss_pkg::FUNC_START: begin
          ctrl.clear   = 1'b1;
          plen_nxt     = '0;
          count_nxt    = '0;
          reported_nxt = 1'b0;
        end
        wss_pkg::FUNC_PAT_CHAR: begin
          if (!reported_r && count_r == '0 && !ch_zero) begin
            if (plen_r >= LEN_W'(MAX_PATTERN)) begin
              emit             = 1'b1;
              out_status_nxt   = wss_pkg::ST_OVERFLOW;
              out_position_nxt = '0;
            end else begin
              load_any = 1'b1;
              plen_nxt = plen_r + 1'b1;
            end
          end
        end
        wss_pkg::FUNC_TXT_CHAR: begin
          if (ch_zero) begin
            if (!reported_r) begin
              emit             = 1'b1;
              out_status_nxt   = (plen_r == '0) ? wss_pkg::ST_MATCH : wss_pkg::ST_NOMATCH;
              out_position_nxt = '0;
            end
          end else if (!reported_r) begin
            if (plen_r == '0) begin
              emit             = 1'b1;
              out_status_nxt   = wss_pkg::ST_MATCH;
              out_position_nxt = '0;
            end else begin
              ctrl.shift = 1'b1;
              if (count_r != '1) begin
                count_nxt = count_r + 1'b1;
              end
              if (|hit) begin
                emit             = 1'b1;
                out_status_nxt   = wss_pkg::ST_MATCH;
                out_position_nxt = count_nxt - wss_pkg::CHAR_W'(plen_r);
              end
            end
          end
        end
        wss_pkg::FUNC_TXT_END: begin
          if (!reported_r) begin
            emit             = 1'b1;
            out_status_nxt   = (plen_r == '0) ? wss_pkg::ST_MATCH : wss_pkg::ST_NOMATCH;
            out_position_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      reported_nxt = 1'b1;
    end
    out_valid_nxt = emit || (out_valid_r && !drained);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      count_r     <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      plen_r      <= plen_nxt;
      count_r     <= count_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;

endmodule

// ===== sv/wss_cell.sv =====
module wss_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wss_pkg::cell_ctrl_t ctrl,
  input  logic                load,
  input  logic                prev_flag,
  output logic                flag_r,
  output logic                flag_nxt
);

  logic [wss_pkg::CHAR_W-1:0] pat_r;

  always_ff @(posedge clk) begin
    if (load) begin
      pat_r <= ctrl.ch;
    end
  end

  always_comb begin
    flag_nxt = flag_r;
    if (ctrl.clear) begin
      flag_nxt = 1'b0;
    end else if (ctrl.shift) begin
      flag_nxt = prev_flag && (ctrl.ch == pat_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

endmodule

// ===== sim/wide_substring_search_tb.sv =====
`timescale 1ns / 1ps

module wide_substring_search_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_REQS    = 1700;
  localparam int TAIL_REQS      = 300;
  localparam int PRESSURE_HOLD  = 300;

  typedef struct packed {
    logic [wss_pkg::STATUS_W-1:0] status;
    logic [wss_pkg::CHAR_W-1:0]   position;
  } search_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [wss_pkg::FUNC_W-1:0]   in_func;
  logic [wss_pkg::CHAR_W-1:0]   in_char_value;
  logic                         out_valid;
  logic                         out_stall;
  logic [wss_pkg::STATUS_W-1:0] out_status;
  logic [wss_pkg::CHAR_W-1:0]   out_position;

  // predictor state
  logic [wss_pkg::CHAR_W-1:0] pat_mem [wss_pkg::MAX_PATTERN_DEF] = '{default: '0};
  logic [wss_pkg::CHAR_W-1:0] txt_win [wss_pkg::MAX_PATTERN_DEF] = '{default: '0};
  int                         pat_len = 0;
  logic [wss_pkg::CHAR_W-1:0] txt_cnt = '0;
  bit                         search_done = 1'b0;
  bit                         pat_overflow = 1'b0;

  search_result_t expected_results [$];
  int n_reqs = 0;
  int n_results = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit no_idle = 1'b0;

  wide_substring_search u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_char_value (in_char_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_position  (out_position)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void predict_search(input logic [wss_pkg::FUNC_W-1:0] f,
                                         input logic [wss_pkg::CHAR_W-1:0] c);
    search_result_t r;
    bit hit;
    bit same;
    bit is_end;
    int k;
    hit = 1'b0;
    r = '0;
    is_end = (f == wss_pkg::FUNC_TXT_END) ||
             (f == wss_pkg::FUNC_TXT_CHAR && c == wss_pkg::TERMINATOR);
    if (f == wss_pkg::FUNC_START) begin
      pat_len = 0;
      txt_win = '{default: '0};
      txt_cnt = '0;
      search_done = 1'b0;
      pat_overflow = 1'b0;
    end else if (is_end) begin
      if (!search_done) begin
        hit = 1'b1;
        r.status = (pat_len == 0) ? wss_pkg::ST_MATCH : wss_pkg::ST_NOMATCH;
      end
    end else if (f == wss_pkg::FUNC_PAT_CHAR) begin
      if (!search_done && txt_cnt == 0 && c != wss_pkg::TERMINATOR) begin
        if (pat_len >= wss_pkg::MAX_PATTERN_DEF) begin
          pat_overflow = 1'b1;
          hit = 1'b1;
          r.status = wss_pkg::ST_OVERFLOW;
        end else begin
          pat_mem[pat_len] = c;
          pat_len++;
        end
      end
    end else if (!search_done) begin
      if (pat_len == 0) begin
        hit = 1'b1;
        r.status = wss_pkg::ST_MATCH;
      end else begin
        for (k = wss_pkg::MAX_PATTERN_DEF - 1; k > 0; k--) txt_win[k] = txt_win[k-1];
        txt_win[0] = c;
        if (txt_cnt != '1) txt_cnt++;
        if (txt_cnt >= pat_len) begin
          same = 1'b1;
          for (k = 0; k < pat_len; k++)
            if (txt_win[pat_len-1-k] != pat_mem[k]) same = 1'b0;
          if (same) begin
            hit = 1'b1;
            r.status = wss_pkg::ST_MATCH;
            r.position = txt_cnt - pat_len;
          end
        end
      end
    end
    if (hit) begin
      search_done = 1'b1;
      expected_results.push_back(r);
    end
  endfunction

  task automatic send_req(input logic [wss_pkg::FUNC_W-1:0] f,
                          input logic [wss_pkg::CHAR_W-1:0] c);
    int gap;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_func = f;
    in_char_value = c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_search(f, c);
    n_reqs++;
    @(negedge clk);
  endtask

  task automatic maybe_noise();
    logic [wss_pkg::FUNC_W-1:0] f;
    if ($urandom_range(0, 29) == 0) begin
      f = wss_pkg::FUNC_W'($urandom_range(wss_pkg::FUNC_PAT_CHAR, wss_pkg::FUNC_TXT_END));
      send_req(f, $urandom_range(0, 1) ? $urandom : wss_pkg::TERMINATOR);
    end
  endtask

  // one start / pattern / text sequence, mostly well formed
  task automatic run_search();
    logic [wss_pkg::CHAR_W-1:0] pat [20];
    logic [wss_pkg::CHAR_W-1:0] base;
    logic [wss_pkg::CHAR_W-1:0] c;
    int kind;
    int spread;
    int plen;
    int tlen;
    int at;
    int i;
    bit plant;
    kind = $urandom_range(0, 99);
    base = ($urandom_range(0, 3) == 0) ? $urandom : 32'd1;
    spread = $urandom_range(1, 3);
    send_req(wss_pkg::FUNC_START, $urandom);
    if (kind < 6)
      plen = $urandom_range(wss_pkg::MAX_PATTERN_DEF + 1, wss_pkg::MAX_PATTERN_DEF + 3);
    else if (kind < 12) plen = 0;
    else if (kind < 70) plen = $urandom_range(1, 4);
    else plen = $urandom_range(5, wss_pkg::MAX_PATTERN_DEF);
    for (i = 0; i < plen; i++) begin
      pat[i] = (kind < 6) ? $urandom : base + $urandom_range(0, spread - 1);
      send_req(wss_pkg::FUNC_PAT_CHAR, pat[i]);
      maybe_noise();
    end
    plant = (plen > 0) && (plen <= wss_pkg::MAX_PATTERN_DEF) && $urandom_range(0, 1);
    at = $urandom_range(0, 20);
    tlen = plant ? at + plen + $urandom_range(0, 5) : $urandom_range(0, 40);
    for (i = 0; i < tlen; i++) begin
      if (plant && i >= at && i < at + plen) c = pat[i-at];
      else c = base + $urandom_range(0, spread - 1);
      send_req(wss_pkg::FUNC_TXT_CHAR, c);
      maybe_noise();
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: send_req(wss_pkg::FUNC_TXT_END, $urandom);
      6, 7:             send_req(wss_pkg::FUNC_TXT_CHAR, wss_pkg::TERMINATOR);
      default:          ;
    endcase
  endtask

  task automatic test_empty_pattern();
    send_req(wss_pkg::FUNC_START, 32'hFFFF_FFFF);
    send_req(wss_pkg::FUNC_TXT_CHAR, 32'h0000_0041);
    send_req(wss_pkg::FUNC_START, '0);
    send_req(wss_pkg::FUNC_TXT_END, '0);
    send_req(wss_pkg::FUNC_START, '0);
    send_req(wss_pkg::FUNC_TXT_CHAR, wss_pkg::TERMINATOR);
  endtask

  task automatic test_no_match();
    send_req(wss_pkg::FUNC_START, '0);
    send_req(wss_pkg::FUNC_PAT_CHAR, wss_pkg::TERMINATOR);
    send_req(wss_pkg::FUNC_PAT_CHAR, 32'hFFFF_FFFF);
    send_req(wss_pkg::FUNC_TXT_CHAR, 32'h7FFF_FFFF);
    send_req(wss_pkg::FUNC_TXT_END, 32'hFFFF_FFFF);
  endtask

  // late pattern chars and anything after the result must be ignored
  task automatic test_match_and_ignored();
    send_req(wss_pkg::FUNC_START, '0);
    send_req(wss_pkg::FUNC_PAT_CHAR, 32'h8000_0000);
    send_req(wss_pkg::FUNC_PAT_CHAR, 32'h0000_0001);
    send_req(wss_pkg::FUNC_TXT_CHAR, 32'h0000_0001);
    send_req(wss_pkg::FUNC_PAT_CHAR, 32'h0000_0002);
    send_req(wss_pkg::FUNC_TXT_CHAR, 32'h8000_0000);
    send_req(wss_pkg::FUNC_TXT_CHAR, 32'h0000_0001);
    send_req(wss_pkg::FUNC_TXT_CHAR, 32'h8000_0000);
    send_req(wss_pkg::FUNC_TXT_END, '0);
    send_req(wss_pkg::FUNC_PAT_CHAR, 32'h0000_0003);
  endtask

  task automatic test_random_searches(input int n);
    int target;
    target = n_reqs + n;
    while (n_reqs < target) run_search();
  endtask

  // receiver holds off while results keep coming, so the input backs up
  task automatic test_backpressure();
    hold_left = PRESSURE_HOLD;
    repeat (8) begin
      send_req(wss_pkg::FUNC_START, '0);
      send_req(wss_pkg::FUNC_TXT_CHAR, $urandom_range(1, 9));
    end
  endtask

  task automatic test_quiet_tail();
    no_idle = 1'b1;
    test_random_searches(TAIL_REQS);
  endtask

  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall = 1'b0;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(1, 7) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0d position %0d", $time, out_status,
                 out_position);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          n_errors++;
        end
        if (out_position !== want.position) begin
          $display("%0t: position expected %0d got %0d", $time, want.position,
                   out_position);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = wss_pkg::FUNC_START;
    in_char_value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_pattern();
    test_no_match();
    test_match_and_ignored();
    test_random_searches(RANDOM_REQS / 2);
    test_backpressure();
    test_random_searches(RANDOM_REQS / 2);
    test_quiet_tail();

    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered empty, short and full-store patterns, overflow, late and zero chars");
    $display("%0d requests sent, %0d results checked", n_reqs, n_results);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
